// ===== hw/rtl/arena_first_fit_lease_table_top_defines.svh =====
// assertion helpers shared by the lease table modules
`ifndef ARENA_FIRST_FIT_LEASE_TABLE_TOP_DEFINES_SVH
`define ARENA_FIRST_FIT_LEASE_TABLE_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define AFFLT_ASSERT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define AFFLT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/afflt_pkg.sv =====
package afflt_pkg;

   // field widths
   localparam int SIZE_W    = 21;
   localparam int OFFS_W    = 20;
   localparam int STATUS_W  = 2;
   localparam int ADDR_BITS = 20;
   localparam int SUM_W     = SIZE_W + 2;
   localparam int ENTRY_W   = OFFS_W + SIZE_W;

   localparam int MAX_ENTRIES_DEFAULT = 16;

   // arena size limits
   localparam logic [SIZE_W-1:0] ARENA_CAP   = SIZE_W'(1) << ADDR_BITS;
   localparam logic [SIZE_W-1:0] ARENA_RESET = SIZE_W'(1048576);

   // command codes
   localparam logic CMD_LEASE   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_SIZE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_READ,
      ST_CHECK,
      ST_GRANT,
      ST_RESULT
   } state_type;

   typedef enum logic [2:0] {
      RES_GRANT,
      RES_BAD_SIZE,
      RES_NO_SPACE,
      RES_FREED,
      RES_MISS
   } result_type;

   // controller to datapath
   typedef struct packed {
      logic       capture;
      logic       scan_init;
      logic       restart;
      logic       rd_en;
      logic       check;
      logic       clear_valid;
      logic       grant_write;
      logic       load_out;
      result_type res_kind;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_release;
      logic size_bad;
      logic hit;
      logic can_grant;
   } dp_status_type;

endpackage

// ===== hw/rtl/afflt_ram.sv =====
module afflt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/afflt_dp.sv =====
`include "arena_first_fit_lease_table_top_defines.svh"

module afflt_dp #(
   parameter int MAX_ENTRIES = afflt_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  afflt_pkg::ctrl_cmd_type               cmd,
   input  logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] scan_idx,
   output afflt_pkg::dp_status_type              status,
   input  logic                                  req_cmd,
   input  logic [afflt_pkg::SIZE_W-1:0]          req_request_size,
   input  logic [afflt_pkg::OFFS_W-1:0]          req_release_offset,
   input  logic                                  csr_write,
   input  logic [afflt_pkg::SIZE_W-1:0]          csr_arena_bytes,
   output logic [afflt_pkg::STATUS_W-1:0]        rsp_status,
   output logic [afflt_pkg::OFFS_W-1:0]          rsp_granted_offset,
   output logic                                  rsp_released
);

   localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int SIZE_W  = afflt_pkg::SIZE_W;
   localparam int OFFS_W  = afflt_pkg::OFFS_W;
   localparam int SUM_W   = afflt_pkg::SUM_W;
   localparam int ENTRY_W = afflt_pkg::ENTRY_W;

   logic                       op_ff;
   logic [SIZE_W-1:0]          size_ff;
   logic [OFFS_W-1:0]          offs_ff;
   logic [SIZE_W-1:0]          arena_ff;
   logic [SUM_W-1:0]           cand_ff;
   logic [MAX_ENTRIES-1:0]     valid_ff;
   logic [MAX_ENTRIES-1:0]     valid_in;
   logic                       slot_found_ff;
   logic [IDX_W-1:0]           slot_ff;
   logic [afflt_pkg::STATUS_W-1:0] out_status_ff;
   logic [OFFS_W-1:0]          out_offset_ff;
   logic                       out_released_ff;

   logic [ENTRY_W-1:0] rd_data;
   logic [OFFS_W-1:0]  rd_start;
   logic [SIZE_W-1:0]  rd_len;
   logic [SUM_W-1:0]   ent_end;
   logic [SUM_W-1:0]   cand_top;
   logic [SIZE_W-1:0]  limit;
   logic               ent_valid;
   logic               overlap;
   logic               match;

   // request capture and arena register
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_cmd;
         size_ff <= req_request_size;
         offs_ff <= req_release_offset;
      end
      if (reset) begin
         arena_ff <= afflt_pkg::ARENA_RESET;
      end else if (csr_write) begin
         arena_ff <= csr_arena_bytes;
      end
   end

   // lease store: start and length per slot
   afflt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_ENTRIES)
   ) u_entries (
      .clock   (clock),
      .wr_en   (cmd.grant_write),
      .wr_addr (slot_ff),
      .wr_data ({cand_ff[OFFS_W-1:0], size_ff}),
      .rd_en   (cmd.rd_en),
      .rd_addr (scan_idx),
      .rd_data (rd_data)
   );

   // overlap and match against the entry just read
   always_comb begin
      rd_start  = rd_data[ENTRY_W-1:SIZE_W];
      rd_len    = rd_data[SIZE_W-1:0];
      ent_end   = SUM_W'(rd_start) + SUM_W'(rd_len);
      cand_top  = cand_ff + SUM_W'(size_ff);
      limit     = (arena_ff > afflt_pkg::ARENA_CAP) ? afflt_pkg::ARENA_CAP : arena_ff;
      ent_valid = valid_ff[scan_idx];
      overlap   = ent_valid && (cand_ff < ent_end) && (SUM_W'(rd_start) < cand_top);
      match     = ent_valid && (rd_start == offs_ff) && (rd_len == size_ff);
   end

   assign status.is_release = (op_ff == afflt_pkg::CMD_RELEASE);
   assign status.size_bad   = (size_ff == '0) || (size_ff > limit);
   assign status.hit        = (op_ff == afflt_pkg::CMD_RELEASE) ? match : overlap;
   assign status.can_grant  = (cand_top <= SUM_W'(limit)) && slot_found_ff;

   // candidate offset
   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         cand_ff <= '0;
      end else if (cmd.restart) begin
         cand_ff <= ent_end;
      end
   end

   // lowest free slot, tracked over each pass
   always_ff @(posedge clock) begin
      if (reset || cmd.scan_init || cmd.restart) begin
         slot_found_ff <= 1'b0;
      end else if (cmd.check && !ent_valid && !slot_found_ff) begin
         slot_found_ff <= 1'b1;
      end
      if (cmd.check && !ent_valid && !slot_found_ff) begin
         slot_ff <= scan_idx;
      end
   end

   // valid bits
   always_comb begin
      valid_in = valid_ff;
      if (cmd.clear_valid) begin
         valid_in[scan_idx] = 1'b0;
      end
      if (cmd.grant_write) begin
         valid_in[slot_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         case (cmd.res_kind)
            afflt_pkg::RES_GRANT: begin
               out_status_ff   <= afflt_pkg::STATUS_OK;
               out_offset_ff   <= cand_ff[OFFS_W-1:0];
               out_released_ff <= 1'b0;
            end
            afflt_pkg::RES_BAD_SIZE: begin
               out_status_ff   <= afflt_pkg::STATUS_BAD_SIZE;
               out_offset_ff   <= '0;
               out_released_ff <= 1'b0;
            end
            afflt_pkg::RES_NO_SPACE: begin
               out_status_ff   <= afflt_pkg::STATUS_NO_SPACE;
               out_offset_ff   <= '0;
               out_released_ff <= 1'b0;
            end
            afflt_pkg::RES_FREED: begin
               out_status_ff   <= afflt_pkg::STATUS_OK;
               out_offset_ff   <= '0;
               out_released_ff <= 1'b1;
            end
            default: begin
               out_status_ff   <= afflt_pkg::STATUS_OK;
               out_offset_ff   <= '0;
               out_released_ff <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_status         = out_status_ff;
   assign rsp_granted_offset = out_offset_ff;
   assign rsp_released       = out_released_ff;

   // a release frees exactly one entry, a grant takes exactly one
   `AFFLT_ASSERT_NEXT(a_release_frees_one, cmd.clear_valid, $countones(valid_ff) == $past($countones(valid_ff)) - 1, "release did not free exactly one entry")
   `AFFLT_ASSERT_NEXT(a_grant_takes_one, cmd.grant_write, $countones(valid_ff) == $past($countones(valid_ff)) + 1, "grant did not take exactly one free slot")

endmodule

// ===== hw/rtl/afflt_ctrl.sv =====
`include "arena_first_fit_lease_table_top_defines.svh"

module afflt_ctrl #(
   parameter int MAX_ENTRIES = afflt_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  afflt_pkg::dp_status_type  status,
   output afflt_pkg::ctrl_cmd_type   cmd,
   output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] scan_idx
);

   localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int PASS_W = $clog2(MAX_ENTRIES + 1);

   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(MAX_ENTRIES - 1);
   localparam logic [PASS_W-1:0] LAST_PASS = PASS_W'(MAX_ENTRIES);

   afflt_pkg::state_type  state_ff, state_in;
   afflt_pkg::result_type kind_ff, kind_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [PASS_W-1:0]     pass_ff, pass_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  out_free;
   logic                  last_entry;
   logic                  last_pass;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign last_entry = (idx_ff == LAST_IDX);
   assign last_pass  = (pass_ff == LAST_PASS);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         afflt_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = afflt_pkg::ST_START;
            end
         end
         afflt_pkg::ST_START: begin
            if (!status.is_release && status.size_bad) begin
               state_in = afflt_pkg::ST_RESULT;
            end else begin
               state_in = afflt_pkg::ST_READ;
            end
         end
         afflt_pkg::ST_READ: begin
            state_in = afflt_pkg::ST_CHECK;
         end
         afflt_pkg::ST_CHECK: begin
            if (status.hit) begin
               if (status.is_release || last_pass) begin
                  state_in = afflt_pkg::ST_RESULT;
               end else begin
                  state_in = afflt_pkg::ST_READ;
               end
            end else if (last_entry) begin
               state_in = status.is_release ? afflt_pkg::ST_RESULT : afflt_pkg::ST_GRANT;
            end else begin
               state_in = afflt_pkg::ST_READ;
            end
         end
         afflt_pkg::ST_GRANT: begin
            state_in = afflt_pkg::ST_RESULT;
         end
         afflt_pkg::ST_RESULT: begin
            if (out_free) begin
               state_in = afflt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = afflt_pkg::ST_IDLE;
         end
      endcase
   end

   // scan index, pass count and result kind
   always_comb begin
      idx_in  = idx_ff;
      pass_in = pass_ff;
      kind_in = kind_ff;
      case (state_ff)
         afflt_pkg::ST_START: begin
            idx_in  = '0;
            pass_in = '0;
            kind_in = afflt_pkg::RES_BAD_SIZE;
         end
         afflt_pkg::ST_CHECK: begin
            if (status.hit) begin
               if (status.is_release) begin
                  kind_in = afflt_pkg::RES_FREED;
               end else if (last_pass) begin
                  kind_in = afflt_pkg::RES_NO_SPACE;
               end else begin
                  pass_in = pass_ff + PASS_W'(1);
                  idx_in  = '0;
               end
            end else if (last_entry) begin
               kind_in = afflt_pkg::RES_MISS;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         afflt_pkg::ST_GRANT: begin
            kind_in = status.can_grant ? afflt_pkg::RES_GRANT : afflt_pkg::RES_NO_SPACE;
         end
         default: begin
         end
      endcase
   end

   // datapath commands
   always_comb begin
      req_ready         = (state_ff == afflt_pkg::ST_IDLE);
      cmd.capture       = (state_ff == afflt_pkg::ST_IDLE) && req_valid;
      cmd.scan_init     = (state_ff == afflt_pkg::ST_START);
      cmd.rd_en         = (state_ff == afflt_pkg::ST_READ);
      cmd.check         = (state_ff == afflt_pkg::ST_CHECK);
      cmd.restart       = (state_ff == afflt_pkg::ST_CHECK) && status.hit &&
                          !status.is_release && !last_pass;
      cmd.clear_valid   = (state_ff == afflt_pkg::ST_CHECK) && status.hit &&
                          status.is_release;
      cmd.grant_write   = (state_ff == afflt_pkg::ST_GRANT) && status.can_grant;
      cmd.load_out      = (state_ff == afflt_pkg::ST_RESULT) && out_free;
      cmd.res_kind      = kind_ff;
   end

   // output valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= afflt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         pass_ff      <= '0;
         kind_ff      <= afflt_pkg::RES_MISS;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         pass_ff      <= pass_in;
         kind_ff      <= kind_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign scan_idx  = idx_ff;

   // sequencing checks
   `AFFLT_ASSERT_NEXT(a_accept_starts, req_valid && req_ready, state_ff == afflt_pkg::ST_START, "accepted request did not start")
   `AFFLT_ASSERT_NEXT(a_grant_result, state_ff == afflt_pkg::ST_GRANT, state_ff == afflt_pkg::ST_RESULT && (kind_ff == afflt_pkg::RES_GRANT || kind_ff == afflt_pkg::RES_NO_SPACE), "grant step gave wrong result kind")
   `AFFLT_ASSERT(a_pass_bound, state_ff != afflt_pkg::ST_IDLE, pass_ff <= LAST_PASS, "first-fit pass count overran")

endmodule

// ===== hw/rtl/arena_first_fit_lease_table_top.sv =====
// First-fit lease table: keeps up to MAX_ENTRIES leased byte ranges of an
// arena and answers one lease or release request at a time, one response per
// request. A lease walks the table from candidate offset 0, jumping past each
// overlapping lease and restarting the walk, and takes the lowest free slot.
// Each table entry visit is a registered read of the entry store, then the
// compare. A lease makes one more walk pass for each jump, an invalid size is
// rejected without a walk, and a release walks the table at most once. The next
// request is taken while a response still waits in the output register.
// The arena size register is to be written through the csr channel only while
// idle; the user is bound by this, and the block itself does not enforce it.
module arena_first_fit_lease_table_top #(
   parameter int MAX_ENTRIES = afflt_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_cmd,
   input  logic [afflt_pkg::SIZE_W-1:0]     req_request_size,
   input  logic [afflt_pkg::OFFS_W-1:0]     req_release_offset,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [afflt_pkg::STATUS_W-1:0]   rsp_status,
   output logic [afflt_pkg::OFFS_W-1:0]     rsp_granted_offset,
   output logic                             rsp_released,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [afflt_pkg::SIZE_W-1:0]     csr_arena_bytes
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   afflt_pkg::ctrl_cmd_type  cmd;
   afflt_pkg::dp_status_type status;
   logic [IDX_W-1:0]         scan_idx;

   // register writes are always taken
   assign csr_ready = 1'b1;

   afflt_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd),
      .scan_idx  (scan_idx)
   );

   afflt_dp #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .scan_idx           (scan_idx),
      .status             (status),
      .req_cmd            (req_cmd),
      .req_request_size   (req_request_size),
      .req_release_offset (req_release_offset),
      .csr_write          (csr_valid && csr_ready),
      .csr_arena_bytes    (csr_arena_bytes),
      .rsp_status         (rsp_status),
      .rsp_granted_offset (rsp_granted_offset),
      .rsp_released       (rsp_released)
   );

endmodule
